// ===== rtl/core/wpos_pkg.sv =====
// shared types, constants and lookup functions of the wind noise sampler
`default_nettype none

package wpos_pkg;

    localparam int PERM_ENTRIES     = 256;
    localparam int OCTAVES_DEF      = 3;
    localparam int SINE_DEPTH_DEF   = 256;
    localparam int OCT_W            = 3;
    localparam int CFG_IDX_W        = 3;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRENGTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GUST_FREQ = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GUST_AMP  = 3'd5;

    localparam logic [15:0] RST_DIR_X     = 16'd16384;
    localparam logic [15:0] RST_DIR_Y     = 16'd0;
    localparam logic [15:0] RST_STRENGTH  = 16'd256;
    localparam logic [15:0] RST_SPEED     = 16'd256;
    localparam logic [15:0] RST_GUST_FREQ = 16'd128;
    localparam logic [15:0] RST_GUST_AMP  = 16'd77;

    localparam logic [23:0] SCROLL_K  = 24'd26214;
    localparam logic [23:0] BASE_FREQ = 24'd6554;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [4:0] {
        OP_TS, OP_D, OP_OX, OP_OY,
        OP_NX, OP_NY,
        OP_FADE1, OP_FADE2, OP_FADE3, OP_FADE4,
        OP_HASH1, OP_HASH2, OP_HASH3,
        OP_L1, OP_L2, OP_L3, OP_W,
        OP_G1, OP_G2, OP_G3, OP_G4, OP_G5, OP_G6, OP_G7, OP_G8,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic             run;
        logic             phase;
        op_t              op;
        logic             axis;
        logic [OCT_W-1:0] oct;
        logic             load_tick;
        logic             load_sample;
        logic             out_load;
    } cmd_t;

    localparam logic [7:0] PERM_ROM [PERM_ENTRIES] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,
        8'd201,8'd95,8'd96,8'd53,8'd194,8'd233,8'd7,8'd225,
        8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,
        8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,
        8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,
        8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
        8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,
        8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
        8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,
        8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,
        8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,
        8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,
        8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,
        8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,
        8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,
        8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,
        8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,
        8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,
        8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,
        8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,
        8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,
        8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
    };

    function automatic logic [7:0] perm(input logic [7:0] idx);
        perm = PERM_ROM[idx];
    endfunction

    function automatic logic [23:0] oct_weight(input logic [OCT_W-1:0] k);
        logic [23:0] w;
        unique case (k)
            3'd0:    w = 24'd45875;
            3'd1:    w = 24'd13107;
            3'd2:    w = 24'd6554;
            default: w = 24'd0;
        endcase
        oct_weight = w;
    endfunction

    // 8-way gradient: +-u +- 2v
    function automatic logic signed [18:0] grad(input logic [7:0] hash,
                                                input logic signed [17:0] x,
                                                input logic signed [17:0] y);
        logic [2:0]         h;
        logic signed [18:0] u;
        logic signed [18:0] v2;
        h  = hash[2:0];
        u  = h[2] ? 19'(y) : 19'(x);
        v2 = h[2] ? (19'(x) <<< 1) : (19'(y) <<< 1);
        grad = (h[0] ? -u : u) + (h[1] ? -v2 : v2);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wind_perlin_octave_sampler_unit.sv =====
// top level of the scrolling perlin wind sampler
//
// usage:
//   input channel (in_valid / in_stall) carries one word per request:
//   req_type 0 is a tick that adds delta_time to the saturating clock,
//   req_type 1 is a sample at pos_x / pos_y that yields one wind_value word
//   output channel (out_valid / out_stall) returns one word per sample
//   cfg channel (cfg_valid / cfg_ready) writes the six wind registers;
//   cfg_ready is always high, writes are expected while the block is idle
// latency / throughput:
//   a tick is absorbed in the cycle it is accepted, next word the cycle after
//   a sample walks its steps one after another, set by the single shared
//   multiplier: every step has an issue phase and a write-back phase, and
//   no new request is taken until the sample is done
// reset:
//   clock cleared, registers take their documented defaults, no word pending
// stall:
//   a finished word waits in the output register; the next request is taken
//   meanwhile, and a new sample holds at its last step until the old word goes
`default_nettype none

module wind_perlin_octave_sampler_unit #(
    parameter int OCTAVES          = wpos_pkg::OCTAVES_DEF,
    parameter int SINE_TABLE_DEPTH = wpos_pkg::SINE_DEPTH_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire                            req_type,
    input  wire [17:0]                     delta_time,
    input  wire signed [31:0]              pos_x,
    input  wire signed [31:0]              pos_y,
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic signed [31:0]             wind_value,
    input  wire                            cfg_valid,
    output logic                           cfg_ready,
    input  wire [wpos_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [15:0]                     cfg_data
);

    wpos_pkg::cmd_t cmd;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    wpos_ctrl #(
        .OCTAVES (OCTAVES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    wpos_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg_valid  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .delta_time (delta_time),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .wind_value (wind_value)
    );

    // an accepted sample makes the block busy
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && req_type) |=> in_stall)
        else $error("sample accepted but block not busy");

    // a new result never overwrites a word still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result loaded over pending word");

    // a word appears only after the final step ran
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("output valid without a load");

    // ticks never start the sequencer
    a_tick_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !req_type) |=> !in_stall)
        else $error("tick left the block busy");

endmodule

`default_nettype wire

// ===== rtl/core/wpos_ctrl.sv =====
// sequencer that walks the datapath through one sample
`default_nettype none

module wpos_ctrl #(
    parameter int OCTAVES = wpos_pkg::OCTAVES_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_stall,
    input  wire              req_type,
    output logic             out_valid,
    input  wire              out_stall,
    output wpos_pkg::cmd_t   cmd
);

    wpos_pkg::state_t             state_reg, state_next;
    wpos_pkg::op_t                op_reg, op_next;
    logic                         phase_reg, phase_next;
    logic                         axis_reg, axis_next;
    logic [wpos_pkg::OCT_W-1:0]   oct_reg, oct_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wpos_pkg::ST_IDLE;
            op_reg        <= wpos_pkg::OP_TS;
            phase_reg     <= 1'b0;
            axis_reg      <= 1'b0;
            oct_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            phase_reg     <= phase_next;
            axis_reg      <= axis_next;
            oct_reg       <= oct_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        phase_next = phase_reg;
        axis_next  = axis_reg;
        oct_next   = oct_reg;
        in_stall   = (state_reg != wpos_pkg::ST_IDLE);
        accept     = in_valid && !in_stall;

        cmd             = '0;
        cmd.run         = (state_reg == wpos_pkg::ST_RUN);
        cmd.phase       = phase_reg;
        cmd.op          = op_reg;
        cmd.axis        = axis_reg;
        cmd.oct         = oct_reg;
        cmd.load_tick   = accept && !req_type;
        cmd.load_sample = accept && req_type;

        unique case (state_reg)
            wpos_pkg::ST_IDLE:
            begin
                if (accept && req_type)
                begin
                    state_next = wpos_pkg::ST_RUN;
                    op_next    = wpos_pkg::OP_TS;
                    phase_next = 1'b0;
                    axis_next  = 1'b0;
                    oct_next   = '0;
                end
            end
            wpos_pkg::ST_RUN:
            begin
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else if (op_reg == wpos_pkg::OP_OUT)
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = wpos_pkg::ST_IDLE;
                        phase_next   = 1'b0;
                    end
                end
                else
                begin
                    phase_next = 1'b0;
                    unique case (op_reg)
                        wpos_pkg::OP_TS:    op_next = wpos_pkg::OP_D;
                        wpos_pkg::OP_D:     op_next = wpos_pkg::OP_OX;
                        wpos_pkg::OP_OX:    op_next = wpos_pkg::OP_OY;
                        wpos_pkg::OP_OY:    op_next = wpos_pkg::OP_NX;
                        wpos_pkg::OP_NX:    op_next = wpos_pkg::OP_NY;
                        wpos_pkg::OP_NY:    op_next = wpos_pkg::OP_FADE1;
                        wpos_pkg::OP_FADE1: op_next = wpos_pkg::OP_FADE2;
                        wpos_pkg::OP_FADE2: op_next = wpos_pkg::OP_FADE3;
                        wpos_pkg::OP_FADE3: op_next = wpos_pkg::OP_FADE4;
                        wpos_pkg::OP_FADE4:
                        begin
                            if (!axis_reg)
                            begin
                                op_next   = wpos_pkg::OP_FADE1;
                                axis_next = 1'b1;
                            end
                            else
                            begin
                                op_next   = wpos_pkg::OP_HASH1;
                                axis_next = 1'b0;
                            end
                        end
                        wpos_pkg::OP_HASH1: op_next = wpos_pkg::OP_HASH2;
                        wpos_pkg::OP_HASH2: op_next = wpos_pkg::OP_HASH3;
                        wpos_pkg::OP_HASH3: op_next = wpos_pkg::OP_L1;
                        wpos_pkg::OP_L1:    op_next = wpos_pkg::OP_L2;
                        wpos_pkg::OP_L2:    op_next = wpos_pkg::OP_L3;
                        wpos_pkg::OP_L3:    op_next = wpos_pkg::OP_W;
                        wpos_pkg::OP_W:
                        begin
                            if (oct_reg == wpos_pkg::OCT_W'(OCTAVES - 1))
                            begin
                                op_next = wpos_pkg::OP_G1;
                            end
                            else
                            begin
                                op_next  = wpos_pkg::OP_NX;
                                oct_next = oct_reg + 1'b1;
                            end
                        end
                        wpos_pkg::OP_G1:    op_next = wpos_pkg::OP_G2;
                        wpos_pkg::OP_G2:    op_next = wpos_pkg::OP_G3;
                        wpos_pkg::OP_G3:    op_next = wpos_pkg::OP_G4;
                        wpos_pkg::OP_G4:    op_next = wpos_pkg::OP_G5;
                        wpos_pkg::OP_G5:    op_next = wpos_pkg::OP_G6;
                        wpos_pkg::OP_G6:    op_next = wpos_pkg::OP_G7;
                        wpos_pkg::OP_G7:    op_next = wpos_pkg::OP_G8;
                        wpos_pkg::OP_G8:    op_next = wpos_pkg::OP_OUT;
                        default:            op_next = op_reg;
                    endcase
                end
            end
            default:
            begin
                state_next = wpos_pkg::ST_IDLE;
            end
        endcase

        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/wpos_dp.sv =====
// datapath: config registers, time, shared multiplier and noise/gust registers
`default_nettype none

module wpos_dp #(
    parameter int SINE_TABLE_DEPTH = wpos_pkg::SINE_DEPTH_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wpos_pkg::cmd_t                 cmd,
    input  wire                            cfg_valid,
    input  wire [wpos_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [15:0]                     cfg_data,
    input  wire [17:0]                     delta_time,
    input  wire signed [31:0]              pos_x,
    input  wire signed [31:0]              pos_y,
    output logic signed [31:0]             wind_value
);

    localparam int SL = $clog2(SINE_TABLE_DEPTH);

    logic signed [15:0] dir_x_reg, dir_y_reg;
    logic [15:0]        strength_reg, speed_reg, gfreq_reg, gamp_reg;
    logic [31:0]        time_reg;
    logic [32:0]        time_sum;

    logic signed [31:0] px_reg, py_reg;
    logic [39:0]        ts_reg;
    logic [38:0]        d_reg;
    logic signed [41:0] sx_reg, sy_reg;
    logic [7:0]         cx_reg, cy_reg;
    logic [15:0]        fx_reg, fy_reg;
    logic [15:0]        ft2_reg, ft3_reg;
    logic signed [21:0] fin_reg;
    logic [16:0]        u_reg, v_reg;
    logic [7:0]         ha_reg, hb_reg;
    logic [7:0]         paa_reg, pab_reg, pba_reg, pbb_reg;
    logic signed [18:0] g00_reg, g10_reg, g01_reg, g11_reg;
    logic signed [19:0] l0_reg, l1_reg, r_reg;
    logic signed [39:0] acc_reg;
    logic [16:0]        z_reg, z2_reg, p_reg;
    logic               neg_reg;
    logic signed [17:0] s_reg;
    logic signed [25:0] gust_reg;
    logic signed [31:0] out_reg;
    logic signed [71:0] prod_reg;

    logic signed [47:0] mul_a;
    logic signed [23:0] mul_b;
    logic [15:0]        ft;
    logic signed [71:0] coord;
    logic [32:0]        pz;
    logic [SL+1:0]      idx;
    logic [SL:0]        qq;
    logic [16:0]        sq;
    logic signed [23:0] noise;
    logic signed [71:0] total;
    logic signed [17:0] fxs, fys;

    assign ft    = cmd.axis ? fy_reg : fx_reg;
    assign coord = prod_reg >>> (16 - int'(cmd.oct));
    assign pz    = prod_reg[48:16];
    assign idx   = (SL+2)'(prod_reg[23:0] >> (22 - SL));
    assign qq    = idx[SL] ? ((SL+1)'(SINE_TABLE_DEPTH) - {1'b0, idx[SL-1:0]})
                           : {1'b0, idx[SL-1:0]};
    assign sq    = (pz > 33'd65536) ? 17'd65536 : pz[16:0];
    assign noise = 24'(acc_reg >>> 16);
    assign total = prod_reg >>> 8;
    assign fxs   = $signed({2'b00, fx_reg});
    assign fys   = $signed({2'b00, fy_reg});
    assign time_sum = {1'b0, time_reg} + {15'd0, delta_time};

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            wpos_pkg::OP_TS:
            begin
                mul_a = $signed({16'd0, time_reg});
                mul_b = $signed({8'd0, speed_reg});
            end
            wpos_pkg::OP_D:
            begin
                mul_a = $signed({8'd0, ts_reg});
                mul_b = $signed(wpos_pkg::SCROLL_K);
            end
            wpos_pkg::OP_OX:
            begin
                mul_a = $signed({9'd0, d_reg});
                mul_b = 24'(dir_x_reg);
            end
            wpos_pkg::OP_OY:
            begin
                mul_a = $signed({9'd0, d_reg});
                mul_b = 24'(dir_y_reg);
            end
            wpos_pkg::OP_NX:
            begin
                mul_a = 48'(sx_reg);
                mul_b = $signed(wpos_pkg::BASE_FREQ);
            end
            wpos_pkg::OP_NY:
            begin
                mul_a = 48'(sy_reg);
                mul_b = $signed(wpos_pkg::BASE_FREQ);
            end
            wpos_pkg::OP_FADE1:
            begin
                mul_a = $signed({32'd0, ft});
                mul_b = $signed({8'd0, ft});
            end
            wpos_pkg::OP_FADE2:
            begin
                mul_a = $signed({32'd0, ft2_reg});
                mul_b = $signed({8'd0, ft});
            end
            wpos_pkg::OP_FADE3:
            begin
                mul_a = $signed({32'd0, ft});
                mul_b = ($signed({8'd0, ft}) * 24'sd6) - 24'sd983040;
            end
            wpos_pkg::OP_FADE4:
            begin
                mul_a = $signed({32'd0, ft3_reg});
                mul_b = 24'(fin_reg);
            end
            wpos_pkg::OP_L1:
            begin
                mul_a = 48'(g10_reg) - 48'(g00_reg);
                mul_b = $signed({7'd0, u_reg});
            end
            wpos_pkg::OP_L2:
            begin
                mul_a = 48'(g11_reg) - 48'(g01_reg);
                mul_b = $signed({7'd0, u_reg});
            end
            wpos_pkg::OP_L3:
            begin
                mul_a = 48'(l1_reg) - 48'(l0_reg);
                mul_b = $signed({7'd0, v_reg});
            end
            wpos_pkg::OP_W:
            begin
                mul_a = (48'(r_reg) + 48'sd65536) >>> 1;
                mul_b = $signed(wpos_pkg::oct_weight(cmd.oct));
            end
            wpos_pkg::OP_G1:
            begin
                mul_a = $signed({16'd0, time_reg});
                mul_b = $signed({8'd0, gfreq_reg});
            end
            wpos_pkg::OP_G2:
            begin
                mul_a = $signed({31'd0, z_reg});
                mul_b = $signed({7'd0, z_reg});
            end
            wpos_pkg::OP_G3:
            begin
                mul_a = 48'sd11;
                mul_b = $signed({7'd0, z2_reg});
            end
            wpos_pkg::OP_G4, wpos_pkg::OP_G5, wpos_pkg::OP_G6:
            begin
                mul_a = $signed({31'd0, p_reg});
                mul_b = $signed({7'd0, z2_reg});
            end
            wpos_pkg::OP_G7:
            begin
                mul_a = $signed({31'd0, z_reg});
                mul_b = $signed({7'd0, p_reg});
            end
            wpos_pkg::OP_G8:
            begin
                mul_a = (48'(s_reg) + 48'sd65536) >>> 1;
                mul_b = $signed({8'd0, gamp_reg});
            end
            wpos_pkg::OP_OUT:
            begin
                mul_a = 48'(noise) + 48'(gust_reg);
                mul_b = $signed({8'd0, strength_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // config registers and elapsed time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_x_reg    <= $signed(wpos_pkg::RST_DIR_X);
            dir_y_reg    <= $signed(wpos_pkg::RST_DIR_Y);
            strength_reg <= wpos_pkg::RST_STRENGTH;
            speed_reg    <= wpos_pkg::RST_SPEED;
            gfreq_reg    <= wpos_pkg::RST_GUST_FREQ;
            gamp_reg     <= wpos_pkg::RST_GUST_AMP;
            time_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    wpos_pkg::CFG_DIR_X:     dir_x_reg    <= $signed(cfg_data);
                    wpos_pkg::CFG_DIR_Y:     dir_y_reg    <= $signed(cfg_data);
                    wpos_pkg::CFG_STRENGTH:  strength_reg <= cfg_data;
                    wpos_pkg::CFG_SPEED:     speed_reg    <= cfg_data;
                    wpos_pkg::CFG_GUST_FREQ: gfreq_reg    <= cfg_data;
                    wpos_pkg::CFG_GUST_AMP:  gamp_reg     <= cfg_data;
                    default:                 ;
                endcase
            end
            if (cmd.load_tick)
                time_reg <= time_sum[32] ? 32'hFFFF_FFFF : time_sum[31:0];
        end
    end

    // working registers, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
        begin
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            acc_reg <= '0;
        end
        if (cmd.out_load)
        begin
            if (total > 72'sd2147483647)
                out_reg <= 32'sh7FFF_FFFF;
            else if (total < -72'sd2147483648)
                out_reg <= 32'sh8000_0000;
            else
                out_reg <= 32'(total);
        end
        if (cmd.run && !cmd.phase)
            prod_reg <= mul_a * mul_b;
        if (cmd.run && cmd.phase)
        begin
            unique case (cmd.op)
                wpos_pkg::OP_TS: ts_reg <= prod_reg[47:8];
                wpos_pkg::OP_D:  d_reg  <= prod_reg[54:16];
                wpos_pkg::OP_OX: sx_reg <= 42'(72'(px_reg) - (prod_reg >>> 14));
                wpos_pkg::OP_OY: sy_reg <= 42'(72'(py_reg) - (prod_reg >>> 14));
                wpos_pkg::OP_NX:
                begin
                    cx_reg <= coord[23:16];
                    fx_reg <= coord[15:0];
                end
                wpos_pkg::OP_NY:
                begin
                    cy_reg <= coord[23:16];
                    fy_reg <= coord[15:0];
                end
                wpos_pkg::OP_FADE1: ft2_reg <= prod_reg[31:16];
                wpos_pkg::OP_FADE2: ft3_reg <= prod_reg[31:16];
                wpos_pkg::OP_FADE3: fin_reg <= 22'((prod_reg >>> 16) + 72'sd655360);
                wpos_pkg::OP_FADE4:
                begin
                    if (cmd.axis)
                        v_reg <= prod_reg[32:16];
                    else
                        u_reg <= prod_reg[32:16];
                end
                wpos_pkg::OP_HASH1:
                begin
                    ha_reg <= wpos_pkg::perm(cx_reg) + cy_reg;
                    hb_reg <= wpos_pkg::perm(cx_reg + 8'd1) + cy_reg;
                end
                wpos_pkg::OP_HASH2:
                begin
                    paa_reg <= wpos_pkg::perm(ha_reg);
                    pab_reg <= wpos_pkg::perm(ha_reg + 8'd1);
                    pba_reg <= wpos_pkg::perm(hb_reg);
                    pbb_reg <= wpos_pkg::perm(hb_reg + 8'd1);
                end
                wpos_pkg::OP_HASH3:
                begin
                    g00_reg <= wpos_pkg::grad(wpos_pkg::perm(paa_reg), fxs, fys);
                    g10_reg <= wpos_pkg::grad(wpos_pkg::perm(pba_reg),
                                              fxs - 18'sd65536, fys);
                    g01_reg <= wpos_pkg::grad(wpos_pkg::perm(pab_reg),
                                              fxs, fys - 18'sd65536);
                    g11_reg <= wpos_pkg::grad(wpos_pkg::perm(pbb_reg),
                                              fxs - 18'sd65536, fys - 18'sd65536);
                end
                wpos_pkg::OP_L1: l0_reg <= 20'(72'(g00_reg) + (prod_reg >>> 16));
                wpos_pkg::OP_L2: l1_reg <= 20'(72'(g01_reg) + (prod_reg >>> 16));
                wpos_pkg::OP_L3: r_reg  <= 20'(72'(l0_reg) + (prod_reg >>> 16));
                wpos_pkg::OP_W:  acc_reg <= acc_reg + 40'(prod_reg);
                wpos_pkg::OP_G1:
                begin
                    z_reg   <= 17'(qq) << (16 - SL);
                    neg_reg <= idx[SL+1];
                end
                wpos_pkg::OP_G2: z2_reg <= pz[16:0];
                wpos_pkg::OP_G3: p_reg  <= 17'(33'd307 - pz);
                wpos_pkg::OP_G4: p_reg  <= 17'(33'd5223 - pz);
                wpos_pkg::OP_G5: p_reg  <= 17'(33'd42334 - pz);
                wpos_pkg::OP_G6: p_reg  <= 17'(33'd102944 - pz);
                wpos_pkg::OP_G7:
                    s_reg <= neg_reg ? -$signed({1'b0, sq}) : $signed({1'b0, sq});
                wpos_pkg::OP_G8: gust_reg <= 26'(prod_reg >>> 8);
                default:         ;
            endcase
        end
    end

    assign wind_value = out_reg;

endmodule

`default_nettype wire
